// ===== rtl/core/interval_set_boundary_list_macros.svh =====
// assertion macros for the interval set block
`ifndef INTERVAL_SET_BOUNDARY_LIST_MACROS_SVH
`define INTERVAL_SET_BOUNDARY_LIST_MACROS_SVH
`define ISBL_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ISBL_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/isbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package isbl_pkg;
  localparam int MAX_BOUNDS = 64;
  localparam int COORD_BITS = 32;

  localparam logic [1:0] CMD_INVERT = 2'd0;
  localparam logic [1:0] CMD_SET_ON = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // list edit applied by every cell together
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [31:0]  range_lo;
    logic [31:0]  range_hi;
    logic [31:0]  query_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       inside_res;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/core/interval_set_boundary_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Interval set held as an ascending row of toggle boundaries, one boundary per
// cell; consecutive pairs mark half-open intervals. A command is accepted only
// when the block is idle and the result register is free or being taken in the
// same cycle. After the accept, the compare state checks every cell against the
// range (or the query point) and decides the status; queries, rejected updates,
// set-on commands that need no edit and the unused command put their result out
// at the end of that state. An accepted update then edits the list one boundary
// per cycle, each cell loading from itself or a neighbor: invert edits two
// boundaries, set-on edits once per boundary it erases plus once per boundary it
// inserts. An output stall holds off the next command.
module interval_set_boundary_list
  import isbl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RUN} state_t;
  state_t   state;
  in_item_t cur;

  coord_t lo_c, hi_c, q_c, cmp_hi;
  coord_t vals [MAX_BOUNDS];
  coord_t prev_vals [MAX_BOUNDS];
  coord_t next_vals [MAX_BOUNDS];

  logic [MAX_BOUNDS-1:0] valid_v, ltsel_v, ltlo_v, lehi_v, eqlo_v, eqhi_v, inr_v;
  logic [MAX_BOUNDS-1:0] prev_valid_v, prev_lt_v, next_valid_v;

  logic [1:0] op;
  logic       sel_hi;
  logic       is_upd, lo_p, hi_p, li_odd, ri_odd, any_inr, multi_inr;
  logic       ins1, ins2, full, q_inside, has_ops, run_done, set_out;
  logic [1:0] st_now;

  // pending list edits of the current command
  logic er_lo, er_hi, er_run, in_lo, in_hi;
  logic er_lo_next, er_hi_next, er_run_next, in_lo_next, in_hi_next;

  assign lo_c = coord_t'(cur.range_lo[COORD_BITS-1:0]);
  assign hi_c = coord_t'(cur.range_hi[COORD_BITS-1:0]);
  assign q_c  = coord_t'(cur.query_point[COORD_BITS-1:0]);
  assign cmp_hi = (cur.cmd == CMD_QUERY) ? q_c : hi_c;

  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);

  assign prev_valid_v = {valid_v[MAX_BOUNDS-2:0], 1'b0};
  assign prev_lt_v    = {ltsel_v[MAX_BOUNDS-2:0], 1'b1};
  assign next_valid_v = {1'b0, valid_v[MAX_BOUNDS-1:1]};

  // flags are thermometer codes over the sorted row, so parity gives position
  assign inr_v     = ~ltlo_v & lehi_v;
  assign lo_p      = |eqlo_v;
  assign hi_p      = |eqhi_v;
  assign li_odd    = ^ltlo_v;
  assign ri_odd    = ^lehi_v;
  assign any_inr   = |inr_v;
  assign multi_inr = |(inr_v[MAX_BOUNDS-1:1] & inr_v[MAX_BOUNDS-2:0]);
  assign ins2      = !li_odd && !ri_odd;
  assign ins1      = li_odd ^ ri_odd;
  assign q_inside  = (|(valid_v & ~lehi_v)) && ri_odd;
  assign is_upd    = (cur.cmd == CMD_INVERT) || (cur.cmd == CMD_SET_ON);

  // full when the net growth does not fit in the free cells at the top
  always_comb begin
    full = 1'b0;
    if (cur.cmd == CMD_INVERT)
      full = !lo_p && !hi_p && valid_v[MAX_BOUNDS-2];
    else if (cur.cmd == CMD_SET_ON)
      full = (ins2 && !any_inr && valid_v[MAX_BOUNDS-2])
             || (((ins2 && any_inr && !multi_inr) || (ins1 && !any_inr))
                 && valid_v[MAX_BOUNDS-1]);
    st_now = ST_OK;
    if (is_upd && !(lo_c < hi_c))
      st_now = ST_EMPTY;
    else if (is_upd && full)
      st_now = ST_FULL;
    has_ops = (st_now == ST_OK)
              && ((cur.cmd == CMD_INVERT)
                  || ((cur.cmd == CMD_SET_ON) && (any_inr || ins1 || ins2)));
  end

  // deletes first so the row never overflows part way through
  always_comb begin
    op = OP_HOLD;
    sel_hi = 1'b0;
    er_lo_next = er_lo;
    er_hi_next = er_hi;
    er_run_next = er_run;
    in_lo_next = in_lo;
    in_hi_next = in_hi;
    if (state == S_RUN) begin
      if (er_lo) begin
        op = OP_DEL;
        er_lo_next = 1'b0;
      end else if (er_hi) begin
        op = OP_DEL;
        sel_hi = 1'b1;
        er_hi_next = 1'b0;
      end else if (er_run) begin
        // erase one boundary inside [lo, hi] per cycle
        op = OP_DEL;
        er_run_next = multi_inr;
      end else if (in_lo) begin
        op = OP_INS;
        in_lo_next = 1'b0;
      end else if (in_hi) begin
        op = OP_INS;
        sel_hi = 1'b1;
        in_hi_next = 1'b0;
      end
    end
  end

  assign run_done = !(er_lo_next || er_hi_next || er_run_next || in_lo_next || in_hi_next);
  assign set_out = ((state == S_CMP) && !has_ops) || ((state == S_RUN) && run_done);

  for (genvar g = 0; g < MAX_BOUNDS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_vals[g] = '0;
    end else begin : g_body
      assign prev_vals[g] = vals[g-1];
    end
    if (g == MAX_BOUNDS - 1) begin : g_tail
      assign next_vals[g] = '0;
    end else begin : g_inner
      assign next_vals[g] = vals[g+1];
    end
    isbl_cell u_cell (
      .clk(clk), .rst(rst), .lo(lo_c), .hi(cmp_hi), .op(op), .sel_hi(sel_hi),
      .prev_val(prev_vals[g]), .prev_valid(prev_valid_v[g]), .prev_lt(prev_lt_v[g]),
      .next_val(next_vals[g]), .next_valid(next_valid_v[g]),
      .val_out(vals[g]), .valid_out(valid_v[g]), .lt_sel(ltsel_v[g]),
      .lt_lo(ltlo_v[g]), .le_hi(lehi_v[g]), .eq_lo(eqlo_v[g]), .eq_hi(eqhi_v[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      er_lo <= 1'b0;
      er_hi <= 1'b0;
      er_run <= 1'b0;
      in_lo <= 1'b0;
      in_hi <= 1'b0;
    end else begin
      out_valid <= set_out || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cur <= in_data;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          out_data.status <= st_now;
          out_data.inside_res <= (cur.cmd == CMD_QUERY) && q_inside;
          if (has_ops) begin
            er_lo <= (cur.cmd == CMD_INVERT) && lo_p;
            er_hi <= (cur.cmd == CMD_INVERT) && hi_p;
            er_run <= (cur.cmd == CMD_SET_ON) && any_inr;
            in_lo <= (cur.cmd == CMD_INVERT) ? !lo_p : !li_odd;
            in_hi <= (cur.cmd == CMD_INVERT) ? !hi_p : !ri_odd;
            state <= S_RUN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          er_lo <= er_lo_next;
          er_hi <= er_hi_next;
          er_run <= er_run_next;
          in_lo <= in_lo_next;
          in_hi <= in_hi_next;
          if (run_done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/isbl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one list position: holds a boundary and compares it against lo and hi.
// an insert or delete is positioned by the first cell that is not below the
// selected key; cells from there on load from a neighbor.
module isbl_cell
  import isbl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire coord_t     lo,
  input  wire coord_t     hi,
  input  wire logic [1:0] op,
  input  wire logic       sel_hi,
  input  wire coord_t     prev_val,
  input  wire logic       prev_valid,
  input  wire logic       prev_lt,
  input  wire coord_t     next_val,
  input  wire logic       next_valid,
  output coord_t          val_out,
  output logic            valid_out,
  output logic            lt_sel,
  output logic            lt_lo,
  output logic            le_hi,
  output logic            eq_lo,
  output logic            eq_hi
);
  coord_t v;
  logic   valid;
  logic   lt_hi;
  coord_t x;

  assign x = sel_hi ? hi : lo;
  assign lt_lo = valid && (v < lo);
  assign lt_hi = valid && (v < hi);
  assign eq_lo = valid && (v == lo);
  assign eq_hi = valid && (v == hi);
  assign le_hi = lt_hi || eq_hi;
  assign lt_sel = sel_hi ? lt_hi : lt_lo;
  assign val_out = v;
  assign valid_out = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      valid <= 1'b0;
    end else begin
      case (op)
        OP_INS: begin
          if (!lt_sel) begin
            // first cell not below the key takes it, the rest move up
            if (prev_lt) begin
              v <= x;
              valid <= 1'b1;
            end else begin
              v <= prev_val;
              valid <= prev_valid;
            end
          end
        end
        OP_DEL: begin
          if (!lt_sel) begin
            v <= next_val;
            valid <= next_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/isbl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "interval_set_boundary_list_macros.svh"
module isbl_checker
  import isbl_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  `ISBL_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ISBL_ASSERT_IMP(a_status_code, clk, rst, out_valid, out_data.status <= ST_FULL)
  `ISBL_ASSERT_IMP(a_inside_ok, clk, rst, out_valid && out_data.inside_res, out_data.status == ST_OK)
  `ISBL_ASSERT_NXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall)
endmodule
bind interval_set_boundary_list isbl_checker u_isbl_checker (.*);
`default_nettype wire
